// File: hw/rtl/pyds_pkg.sv
// ----------------------------------------------------------------------------
// pyds_pkg
// Shared types and constants of the planar YUV decimating downscaler.
// ----------------------------------------------------------------------------
package pyds_pkg;

	localparam int CFG_W   = 14;
	localparam int PIX_W   = 8;
	localparam int PLANE_W = 2;
	localparam int CFG_IDX_W = 2;

	typedef logic [PLANE_W-1:0]   plane_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam plane_t PLANE_Y = 2'd0;
	localparam plane_t PLANE_U = 2'd1;
	localparam plane_t PLANE_V = 2'd2;

	localparam cfg_idx_t REG_SOURCE_WIDTH  = 2'd0;
	localparam cfg_idx_t REG_SOURCE_HEIGHT = 2'd1;
	localparam cfg_idx_t REG_TARGET_WIDTH  = 2'd2;
	localparam cfg_idx_t REG_TARGET_HEIGHT = 2'd3;

	localparam int RST_SOURCE_WIDTH  = 640;
	localparam int RST_SOURCE_HEIGHT = 480;
	localparam int RST_TARGET_WIDTH  = 320;
	localparam int RST_TARGET_HEIGHT = 240;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV_H,
		ST_DIV_V,
		ST_EVAL
	} pyds_state_t;

endpackage

// File: hw/rtl/pyds_div.sv
// ----------------------------------------------------------------------------
// pyds_div
// Restoring divider, one quotient bit per cycle; quotient and remainder.
// ----------------------------------------------------------------------------
module pyds_div #(
	parameter int W = 14
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quotient,
	output logic [W-1:0] remainder
);

	localparam int CNT_W = $clog2(W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     rem_q;
	logic [W-1:0]     dvs_q;
	logic [W:0]       trial;
	logic [W:0]       diff;
	logic             ge;

	always_comb begin
		trial = {rem_q, quo_q[W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(W - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[W-2:0], ge};
			rem_q <= ge ? diff[W-1:0] : trial[W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: hw/rtl/planar_yuv_decimating_downscaler.sv
// ----------------------------------------------------------------------------
// planar_yuv_decimating_downscaler
// Nearest-neighbour integer decimation with centred crop over Y, U, V planes.
// ----------------------------------------------------------------------------
// Source bytes arrive in raster order, luma plane then two half-size chroma
// planes. An ordinary item is evaluated as it is accepted, so a plane streams
// at one pixel per cycle while the output is drained. For the first pixel of
// each plane the horizontal and vertical ratios and crop offsets come out of
// one shared bit-serial divider, run twice back to back, and input is held
// off meanwhile. A plane whose target size is zero skips the divider.
// A full output register that is not drained holds input off as well.
// A result leaves only for a kept pixel or for the last pixel of a frame.
module planar_yuv_decimating_downscaler
	import pyds_pkg::*;
#(
	parameter int MAX_DIMENSION = 8192
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [7:0] pixel_in
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [7:0]           m_tdata,   // [7:0] pixel_out
	output logic [3:0]           m_tuser,   // [0] kept, [2:1] plane_id, [3] size_error
	output logic                 m_tlast    // frame_last
);

	localparam int DIM_W = ($clog2(MAX_DIMENSION + 1) < CFG_W) ?
		$clog2(MAX_DIMENSION + 1) : CFG_W;
	localparam int MAX_V = (MAX_DIMENSION < (2**CFG_W - 1)) ?
		MAX_DIMENSION : (2**CFG_W - 1);
	localparam logic [DIM_W-1:0] RST_SW = DIM_W'((MAX_V < RST_SOURCE_WIDTH) ?
		MAX_V : RST_SOURCE_WIDTH);
	localparam logic [DIM_W-1:0] RST_SH = DIM_W'((MAX_V < RST_SOURCE_HEIGHT) ?
		MAX_V : RST_SOURCE_HEIGHT);
	localparam logic [DIM_W-1:0] RST_DW = DIM_W'((MAX_V < RST_TARGET_WIDTH) ?
		MAX_V : RST_TARGET_WIDTH);
	localparam logic [DIM_W-1:0] RST_DH = DIM_W'((MAX_V < RST_TARGET_HEIGHT) ?
		MAX_V : RST_TARGET_HEIGHT);

	// configuration
	logic [DIM_W-1:0] srcw_q, srch_q, dstw_q, dsth_q;
	logic [DIM_W-1:0] cfg_val;

	// frame state
	pyds_state_t      state_q, state_d;
	plane_t           plane_q;
	logic [DIM_W-1:0] col_q, row_q;
	logic [DIM_W-1:0] hr_q, vr_q, hoff_q;
	logic             err_q;
	logic [DIM_W:0]   ncol_q, nrow_q;
	logic [DIM_W-1:0] kcol_q, krow_q;
	logic [PIX_W-1:0] pix_q;

	// output register
	logic             out_vld_q;
	logic [PIX_W-1:0] out_pix_q;
	logic             out_kept_q;
	plane_t           out_plane_q;
	logic             out_last_q;
	logic             out_err_q;

	// plane sizes
	logic             chroma;
	logic [DIM_W-1:0] sw, sh, dw, dh;
	logic             src_empty;
	logic             start_need;
	logic             size_zero;

	// control
	logic             out_free;
	logic             accept;
	logic             do_eval;
	logic             size_fail;
	logic             div_start;
	logic             div_sel_v;
	logic             ld_h;
	logic             ld_v;

	// divider
	logic [DIM_W-1:0] div_a, div_b;
	logic             div_done;
	logic [DIM_W-1:0] div_quo, div_rem;

	// evaluation
	logic [PIX_W-1:0] ev_pix_in;
	logic [DIM_W-1:0] col_inc, row_inc;
	logic             col_hit, row_hit;
	logic             ev_kept, ev_last, ev_err;
	plane_t           ev_plane;
	logic [DIM_W-1:0] col_n, row_n, kcol_n, krow_n;
	logic [DIM_W:0]   ncol_n, nrow_n;
	plane_t           plane_n;
	logic             err_n;

	assign cfg_val = ({{(32 - CFG_W){1'b0}}, cfg_data} > 32'(MAX_V)) ?
		DIM_W'(MAX_V) : cfg_data[DIM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srcw_q <= RST_SW;
			srch_q <= RST_SH;
			dstw_q <= RST_DW;
			dsth_q <= RST_DH;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  srcw_q <= cfg_val;
				REG_SOURCE_HEIGHT: srch_q <= cfg_val;
				REG_TARGET_WIDTH:  dstw_q <= cfg_val;
				REG_TARGET_HEIGHT: dsth_q <= cfg_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		chroma     = plane_q != PLANE_Y;
		sw         = chroma ? (srcw_q >> 1) : srcw_q;
		sh         = chroma ? (srch_q >> 1) : srch_q;
		dw         = chroma ? (dstw_q >> 1) : dstw_q;
		dh         = chroma ? (dsth_q >> 1) : dsth_q;
		src_empty  = (srcw_q == '0) || (srch_q == '0);
		start_need = !src_empty && (row_q == '0) && (col_q == '0);
		size_zero  = (dw == '0) || (dh == '0);
		out_free   = !out_vld_q || m_tready;
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && start_need)
					state_d = size_zero ? ST_EVAL : ST_DIV_H;
			end
			ST_DIV_H: begin
				if (div_done)
					state_d = ST_DIV_V;
			end
			ST_DIV_V: begin
				if (div_done)
					state_d = ST_EVAL;
			end
			ST_EVAL: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		s_tready  = (state_q == ST_IDLE) && out_free;
		accept    = s_tvalid && s_tready;
		do_eval   = 1'b0;
		size_fail = 1'b0;
		div_start = 1'b0;
		div_sel_v = 1'b0;
		ld_h      = 1'b0;
		ld_v      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!start_need)
						do_eval = 1'b1;
					else if (size_zero)
						size_fail = 1'b1;
					else
						div_start = 1'b1;
				end
			end
			ST_DIV_H: begin
				if (div_done) begin
					ld_h      = 1'b1;
					div_start = 1'b1;
					div_sel_v = 1'b1;
				end
			end
			ST_DIV_V: begin
				ld_v = div_done;
			end
			ST_EVAL: begin
				do_eval = out_free;
			end
			default: ;
		endcase
	end

	assign div_a = div_sel_v ? sh : sw;
	assign div_b = div_sel_v ? dh : dw;

	pyds_div #(
		.W(DIM_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_a),
		.divisor   (div_b),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// per-pixel decision; grid trackers hold the next hit position and hit count
	always_comb begin
		ev_pix_in = (state_q == ST_EVAL) ? pix_q : s_tdata;
		col_inc   = col_q + DIM_W'(1);
		row_inc   = row_q + DIM_W'(1);
		col_hit   = {1'b0, col_q} == ncol_q;
		row_hit   = {1'b0, row_q} == nrow_q;
		ev_kept   = !err_q && row_hit && (krow_q < dh) && col_hit && (kcol_q < dw);
		ev_last   = 1'b0;
		ev_plane  = plane_q;
		col_n     = col_inc;
		row_n     = row_q;
		plane_n   = plane_q;
		err_n     = err_q;
		ncol_n    = col_hit ? (ncol_q + {1'b0, hr_q}) : ncol_q;
		kcol_n    = col_hit ? (kcol_q + DIM_W'(1)) : kcol_q;
		nrow_n    = nrow_q;
		krow_n    = krow_q;
		if (col_inc >= sw) begin
			col_n  = '0;
			row_n  = row_inc;
			ncol_n = {1'b0, hoff_q};
			kcol_n = '0;
			if (row_hit) begin
				nrow_n = nrow_q + {1'b0, vr_q};
				krow_n = krow_q + DIM_W'(1);
			end
			if (row_inc >= sh) begin
				row_n = '0;
				case (plane_q)
					PLANE_Y: begin
						if ((srcw_q >> 1) == '0 || (srch_q >> 1) == '0) begin
							err_n   = 1'b1;
							ev_last = 1'b1;
						end else begin
							plane_n = PLANE_U;
						end
					end
					PLANE_U: plane_n = PLANE_V;
					default: ev_last = 1'b1;
				endcase
			end
		end
		ev_err = err_n;
		if (src_empty) begin
			ev_kept  = 1'b0;
			ev_last  = 1'b1;
			ev_err   = 1'b1;
			ev_plane = PLANE_Y;
		end
		if (ev_last) begin
			col_n   = '0;
			row_n   = '0;
			plane_n = PLANE_Y;
			err_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			plane_q <= PLANE_Y;
			col_q   <= '0;
			row_q   <= '0;
			hr_q    <= '0;
			vr_q    <= '0;
			hoff_q  <= '0;
			err_q   <= 1'b0;
			ncol_q  <= '0;
			nrow_q  <= '0;
			kcol_q  <= '0;
			krow_q  <= '0;
		end else begin
			state_q <= state_d;
			if (size_fail) begin
				hr_q   <= '0;
				vr_q   <= '0;
				hoff_q <= '0;
				err_q  <= 1'b1;
				ncol_q <= '0;
				nrow_q <= '0;
				kcol_q <= '0;
				krow_q <= '0;
			end
			if (ld_h) begin
				hr_q   <= div_quo;
				hoff_q <= div_rem >> 1;
			end
			if (ld_v) begin
				kcol_q <= '0;
				krow_q <= '0;
				if (hr_q == '0 || div_quo == '0) begin
					hr_q   <= '0;
					vr_q   <= '0;
					hoff_q <= '0;
					err_q  <= 1'b1;
					ncol_q <= '0;
					nrow_q <= '0;
				end else begin
					vr_q   <= div_quo;
					ncol_q <= {1'b0, hoff_q};
					nrow_q <= {1'b0, div_rem >> 1};
				end
			end
			if (do_eval) begin
				plane_q <= plane_n;
				col_q   <= col_n;
				row_q   <= row_n;
				err_q   <= err_n;
				ncol_q  <= ncol_n;
				nrow_q  <= nrow_n;
				kcol_q  <= kcol_n;
				krow_q  <= krow_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			pix_q <= s_tdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (do_eval && (ev_kept || ev_last)) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_eval && (ev_kept || ev_last)) begin
			out_pix_q   <= ev_kept ? ev_pix_in : '0;
			out_kept_q  <= ev_kept;
			out_plane_q <= ev_plane;
			out_last_q  <= ev_last;
			out_err_q   <= ev_err;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_pix_q;
	assign m_tuser  = {out_err_q, out_plane_q, out_kept_q};
	assign m_tlast  = out_last_q;

`ifndef ASSERT_OFF
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_DIV_H || state_q == ST_DIV_V))
		else $error("divider finished outside a division step");

	a_zero_ratio_err: assert property (@(posedge clk) disable iff (!arst_n)
		((row_q != '0 || col_q != '0) && (hr_q == '0 || vr_q == '0)) |-> err_q)
		else $error("zero ratio inside a plane without error flag");

	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		plane_q == PLANE_Y || plane_q == PLANE_U || plane_q == PLANE_V)
		else $error("plane index out of range");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_H && !div_done) |=> !s_tready)
		else $error("input taken during plane-start division");
`endif

endmodule

// File: sim/pyds_checker.sv
// ----------------------------------------------------------------------------
// pyds_checker
// Watches the register port and both streams of the downscaler, predicts
// every result from the accepted pixels and compares it field by field.
// ----------------------------------------------------------------------------
module pyds_checker
	import pyds_pkg::*;
#(
	parameter int MAX_DIMENSION = 8192
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  cfg_idx_t         cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             s_tvalid,
	input  logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] pixel_in
	input  logic             m_tvalid,
	input  logic             m_tready,
	input  logic [7:0]       m_tdata,   // [7:0] pixel_out
	input  logic [3:0]       m_tuser,   // [0] kept, [2:1] plane_id, [3] size_error
	input  logic             m_tlast,   // frame_last
	output int               fail_count,
	output int               pending,
	output int               checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             kept;
		plane_t           plane;
		logic             last;
		logic             err;
	} sample_t;

	sample_t     expected_samples[$];
	sample_t     head;
	logic [CFG_W-1:0] reg_val;

	int unsigned src_w, src_h, dst_w, dst_h;
	plane_t      plane_idx;
	int unsigned row_cnt, col_cnt;
	int unsigned h_ratio, v_ratio, h_off, v_off;
	logic        err_flag;

	function automatic bit on_grid(int unsigned pos, int unsigned off, int unsigned ratio,
			int unsigned dst);
		int unsigned d;
		if (ratio == 0 || pos < off)
			return 1'b0;
		d = pos - off;
		return (d % ratio == 0) && (d / ratio < dst);
	endfunction

	task automatic predict_pixel(input logic [PIX_W-1:0] pix);
		plane_t      p;
		int unsigned sft, sw, sh, dw, dh, hr, vr;
		bit          kept, last;
		sample_t     s;
		// empty luma plane: every item closes a frame on its own
		if (src_w == 0 || src_h == 0) begin
			plane_idx = PLANE_Y;
			row_cnt = 0;
			col_cnt = 0;
			err_flag = 1'b0;
			s.pixel = '0;
			s.kept = 1'b0;
			s.plane = PLANE_Y;
			s.last = 1'b1;
			s.err = 1'b1;
			expected_samples.push_back(s);
			return;
		end
		p = (plane_idx > PLANE_V) ? PLANE_Y : plane_idx;
		sft = (p == PLANE_Y) ? 0 : 1;
		sw = src_w >> sft;
		sh = src_h >> sft;
		dw = dst_w >> sft;
		dh = dst_h >> sft;
		// ratios and crop offsets latch at the first pixel of a plane
		if (row_cnt == 0 && col_cnt == 0) begin
			hr = 0;
			vr = 0;
			if (dw != 0 && dh != 0) begin
				hr = sw / dw;
				vr = sh / dh;
			end
			if (hr == 0 || vr == 0) begin
				err_flag = 1'b1;
				h_ratio = 0;
				v_ratio = 0;
				h_off = 0;
				v_off = 0;
			end else begin
				h_ratio = hr;
				v_ratio = vr;
				h_off = (sw - dw * hr) >> 1;
				v_off = (sh - dh * vr) >> 1;
			end
		end
		kept = !err_flag && on_grid(row_cnt, v_off, v_ratio, dh) &&
			on_grid(col_cnt, h_off, h_ratio, dw);
		last = 1'b0;
		col_cnt++;
		if (col_cnt >= sw) begin
			col_cnt = 0;
			row_cnt++;
			if (row_cnt >= sh) begin
				row_cnt = 0;
				if (p == PLANE_Y) begin
					if ((src_w >> 1) == 0 || (src_h >> 1) == 0) begin
						err_flag = 1'b1;
						last = 1'b1;
					end else begin
						plane_idx = PLANE_U;
					end
				end else if (p == PLANE_U) begin
					plane_idx = PLANE_V;
				end else begin
					last = 1'b1;
				end
			end
		end
		if (kept || last) begin
			s.pixel = kept ? pix : '0;
			s.kept = kept;
			s.plane = p;
			s.last = last;
			s.err = err_flag;
			expected_samples.push_back(s);
		end
		if (last) begin
			plane_idx = PLANE_Y;
			row_cnt = 0;
			col_cnt = 0;
			err_flag = 1'b0;
		end
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w = RST_SOURCE_WIDTH;
			src_h = RST_SOURCE_HEIGHT;
			dst_w = RST_TARGET_WIDTH;
			dst_h = RST_TARGET_HEIGHT;
			plane_idx = PLANE_Y;
			row_cnt = 0;
			col_cnt = 0;
			h_ratio = 0;
			v_ratio = 0;
			h_off = 0;
			v_off = 0;
			err_flag = 1'b0;
			expected_samples.delete();
			fail_count = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				reg_val = (cfg_data > MAX_DIMENSION) ? CFG_W'(MAX_DIMENSION) : cfg_data;
				case (cfg_index)
					REG_SOURCE_WIDTH:  src_w = reg_val;
					REG_SOURCE_HEIGHT: src_h = reg_val;
					REG_TARGET_WIDTH:  dst_w = reg_val;
					REG_TARGET_HEIGHT: dst_h = reg_val;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				predict_pixel(s_tdata);
			if (m_tvalid && m_tready) begin
				if (expected_samples.size() == 0) begin
					report_mismatch($sformatf("unexpected item data %h user %b last %b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					head = expected_samples.pop_front();
					checked++;
					if (m_tdata !== head.pixel)
						report_mismatch($sformatf("pixel_out %h, expected %h",
							m_tdata, head.pixel));
					if (m_tuser[0] !== head.kept)
						report_mismatch($sformatf("kept %b, expected %b",
							m_tuser[0], head.kept));
					if (m_tuser[2:1] !== head.plane)
						report_mismatch($sformatf("plane_id %0d, expected %0d",
							m_tuser[2:1], head.plane));
					if (m_tlast !== head.last)
						report_mismatch($sformatf("frame_last %b, expected %b",
							m_tlast, head.last));
					if (m_tuser[3] !== head.err)
						report_mismatch($sformatf("size_error %b, expected %b",
							m_tuser[3], head.err));
				end
			end
			pending <= expected_samples.size();
		end
	end

endmodule

// File: sim/tb_planar_yuv_decimating_downscaler.sv
// ----------------------------------------------------------------------------
// tb_planar_yuv_decimating_downscaler
// Drives pixel frames and size settings into the downscaler under random
// back-pressure; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_planar_yuv_decimating_downscaler;
	timeunit 1ns;
	timeprecision 1ps;
	import pyds_pkg::*;

	localparam int LIMIT_CYCLES = 1_000_000;
	localparam int DRAIN_CYCLES = 40;    // plane start divider
	localparam int RANDOM_ITEMS = 330;
	localparam int EDGE_ITEMS   = 64;

	typedef enum {PACE_RX_SLOW, PACE_TX_SLOW, PACE_FREE} pace_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cfg_we = 1'b0;
	cfg_idx_t         cfg_index = REG_SOURCE_WIDTH;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic [3:0]       m_tuser;
	logic             m_tlast;

	int    fail_count, pending, checked;
	pace_t pace = PACE_RX_SLOW;
	int    items_sent = 0;
	int    settings_used = 0;
	int    cycle_count = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	planar_yuv_decimating_downscaler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	pyds_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending), .checked(checked)
	);

	always @(posedge clk) begin
		m_tready <= $urandom_range(0, 99) >=
			((pace == PACE_RX_SLOW) ? 60 : (pace == PACE_TX_SLOW) ? 16 : 0);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("Run stopped after %0d cycles, %0d results outstanding",
				cycle_count, pending);
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_pixel(input logic [7:0] pix);
		int pct;
		pct = (pace == PACE_RX_SLOW) ? 16 : (pace == PACE_TX_SLOW) ? 60 : 0;
		while ($urandom_range(0, 99) < pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic drain;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input int unsigned sw, input int unsigned sh,
			input int unsigned tw, input int unsigned th);
		cfg_we <= 1'b1;
		cfg_index <= REG_SOURCE_WIDTH;
		cfg_data <= CFG_W'(sw);
		@(posedge clk);
		cfg_index <= REG_SOURCE_HEIGHT;
		cfg_data <= CFG_W'(sh);
		@(posedge clk);
		cfg_index <= REG_TARGET_WIDTH;
		cfg_data <= CFG_W'(tw);
		@(posedge clk);
		cfg_index <= REG_TARGET_HEIGHT;
		cfg_data <= CFG_W'(th);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin : stimulus
		int unsigned sw, sh, tw, th, flen, n, base, done;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes, then left mid-frame by the next setting
		for (int i = 0; i < 4; i++)
			send_pixel(8'(i * 85));
		drain;
		// zero width: each item is a frame of its own
		configure(0, 2, 2, 1);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		drain;
		// chroma targets collapse to zero height
		configure(4, 2, 2, 1);
		for (int i = 0; i < 12; i++)
			send_pixel(8'($urandom_range(0, 255)));
		drain;
		// chroma planes empty, frame ends on luma
		configure(1, 2, 1, 1);
		send_pixel(8'hFF);
		send_pixel(8'h00);
		drain;
		// full keep, frame ends on a kept chroma pixel
		configure(2, 2, 2, 2);
		for (int i = 0; i < 6; i++)
			send_pixel(i[0] ? 8'hFF : 8'h00);
		drain;

		// widest and tallest settings, first pixels only; oversized writes saturate
		configure(CFG_W'(16383), 1, 8192, 1);
		repeat (EDGE_ITEMS) send_pixel(8'($urandom_range(0, 255)));
		drain;
		configure(1, 8192, 1, 3);
		repeat (EDGE_ITEMS) send_pixel(8'($urandom_range(0, 255)));
		drain;

		base = items_sent;
		done = 0;
		while (done < RANDOM_ITEMS) begin
			pace = (done < RANDOM_ITEMS / 3) ? PACE_RX_SLOW :
				(done < 2 * RANDOM_ITEMS / 3) ? PACE_TX_SLOW : PACE_FREE;
			sw = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 12);
			sh = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8);
			tw = $urandom_range(0, sw + 1);
			th = $urandom_range(0, sh + 1);
			if (sw == 0 || sh == 0)
				flen = 1;
			else if (sw / 2 == 0 || sh / 2 == 0)
				flen = sw * sh;
			else
				flen = sw * sh + 2 * (sw / 2) * (sh / 2);
			// mostly whole frames, sometimes a trailing partial one
			n = flen * $urandom_range(1, 3);
			if ($urandom_range(0, 3) == 0)
				n += $urandom_range(1, flen);
			configure(sw, sh, tw, th);
			repeat (n) send_pixel(8'($urandom_range(0, 255)));
			drain;
			done = items_sent - base;
		end

		$display("Summary: %0d items in, %0d results checked, %0d size settings",
			items_sent, checked, settings_used);
		$display("Covered zero and saturated sizes, 8192-wide and -high settings, size errors, "
			, "mid-frame size changes and three back-pressure mixes");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
